@@ src/btb_pkg.sv @@
// Shared constants for the bone transform blend.
package btb_pkg;

  localparam int XYZ_LANES  = 3;
  localparam int QUAT_LANES = 4;

endpackage

@@ src/btb_lerp_pipe.sv @@
// Three-stage lane-parallel lerp: a + floor((b - a) * t / 2^WF).
module btb_lerp_pipe #(
  parameter int LANE_W = 16,
  parameter int LANES  = 3,
  parameter int WF     = 16
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [LANES*LANE_W-1:0]   a_i,
  input  logic [LANES*LANE_W-1:0]   b_i,
  input  logic [WF:0]               t_i,
  output logic [LANES*LANE_W-1:0]   res_o
);

  localparam int PW = LANE_W + WF + 3;

  logic [LANES*LANE_W-1:0] a1_q, b1_q, a2_q;
  logic [WF:0]             t1_q;
  logic signed [PW-1:0]    p2_q  [LANES];
  logic [LANE_W-1:0]       res_q [LANES];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q <= a_i;
      b1_q <= b_i;
      t1_q <= t_i;
      a2_q <= a1_q;
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    localparam int SH = (LANES - 1 - i) * LANE_W;
    logic signed [LANE_W:0]  diff;
    logic signed [WF+1:0]    t_s;
    logic signed [PW-1:0]    p_d;
    logic signed [PW-1:0]    q_sh;

    assign diff = signed'({b1_q[SH+LANE_W-1], b1_q[SH+:LANE_W]}
                        - {a1_q[SH+LANE_W-1], a1_q[SH+:LANE_W]});
    assign t_s  = signed'({1'b0, t1_q});
    assign p_d  = diff * t_s;
    assign q_sh = p2_q[i] >>> WF;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        p2_q[i]  <= p_d;
        res_q[i] <= a2_q[SH+:LANE_W] + q_sh[LANE_W-1:0];
      end
    end

    assign res_o[SH+:LANE_W] = res_q[i];
  end

endmodule

@@ src/bone_transform_blend.sv @@
// Bone pose blend: lerp of translation and scale, nlerp of the rotation quaternion.
// Throughput: one transfer per cycle while no result is held by an output stall;
// the exact normalization is a bit-serial root search with one result bit per
// pipeline stage, no multiplier in it.
// A stall at the output freezes the whole pipeline while a valid result waits there.
// Reset clears the valid bits only; payload registers are not reset.
module bone_transform_blend #(
  parameter int TRANSLATION_WIDTH = 20,
  parameter int ROTATION_WIDTH    = 16,
  parameter int SCALE_WIDTH       = 16,
  parameter int WEIGHT_FRAC_BITS  = 16
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            in_valid_i,
  output logic                                            in_stall_o,
  input  logic [btb_pkg::XYZ_LANES*TRANSLATION_WIDTH-1:0] a_translation_i,
  input  logic [btb_pkg::QUAT_LANES*ROTATION_WIDTH-1:0]   a_rotation_i,
  input  logic [btb_pkg::XYZ_LANES*SCALE_WIDTH-1:0]       a_scale_i,
  input  logic [btb_pkg::XYZ_LANES*TRANSLATION_WIDTH-1:0] b_translation_i,
  input  logic [btb_pkg::QUAT_LANES*ROTATION_WIDTH-1:0]   b_rotation_i,
  input  logic [btb_pkg::XYZ_LANES*SCALE_WIDTH-1:0]       b_scale_i,
  input  logic [WEIGHT_FRAC_BITS:0]                       blend_weight_i,
  output logic                                            out_valid_o,
  input  logic                                            out_stall_i,
  output logic [btb_pkg::XYZ_LANES*TRANSLATION_WIDTH-1:0] out_translation_o,
  output logic [btb_pkg::QUAT_LANES*ROTATION_WIDTH-1:0]   out_rotation_o,
  output logic [btb_pkg::XYZ_LANES*SCALE_WIDTH-1:0]       out_scale_o,
  output logic                                            zero_length_o
);

  import btb_pkg::*;

  localparam int RW    = ROTATION_WIDTH;
  localparam int NB    = RW - 1;
  localparam int AW    = 4 * RW + 2;
  localparam int SQW   = 2 * RW;
  localparam int SSW   = 2 * RW + 1;
  localparam int DEPTH = NB + 6;
  localparam int DLY   = NB + 3;
  localparam int TRW   = XYZ_LANES * TRANSLATION_WIDTH;
  localparam int SCW   = XYZ_LANES * SCALE_WIDTH;
  localparam int ROTW  = QUAT_LANES * RW;
  localparam logic [WEIGHT_FRAC_BITS:0] T_ONE = {1'b1, {WEIGHT_FRAC_BITS{1'b0}}};
  localparam logic [NB-1:0] UNIT = NB'(1) << (RW - 2);

  logic                     en;
  logic [DEPTH-1:0]         valid_q;
  logic [WEIGHT_FRAC_BITS:0] t_cl;
  logic [TRW-1:0]           tr_res;
  logic [SCW-1:0]           sc_res;
  logic [ROTW-1:0]          rot_res;

  assign in_stall_o = valid_q[DEPTH-1] & out_stall_i;
  assign en         = ~in_stall_o;
  assign t_cl       = (blend_weight_i > T_ONE) ? T_ONE : blend_weight_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[DEPTH-2:0], in_valid_i};
    end
  end

  btb_lerp_pipe #(.LANE_W(TRANSLATION_WIDTH), .LANES(XYZ_LANES), .WF(WEIGHT_FRAC_BITS))
    u_tr_lerp (.clk_i, .en_i(en), .a_i(a_translation_i), .b_i(b_translation_i),
               .t_i(t_cl), .res_o(tr_res));

  btb_lerp_pipe #(.LANE_W(SCALE_WIDTH), .LANES(XYZ_LANES), .WF(WEIGHT_FRAC_BITS))
    u_sc_lerp (.clk_i, .en_i(en), .a_i(a_scale_i), .b_i(b_scale_i),
               .t_i(t_cl), .res_o(sc_res));

  btb_lerp_pipe #(.LANE_W(RW), .LANES(QUAT_LANES), .WF(WEIGHT_FRAC_BITS))
    u_rot_lerp (.clk_i, .en_i(en), .a_i(a_rotation_i), .b_i(b_rotation_i),
                .t_i(t_cl), .res_o(rot_res));

  // translation and scale ride alongside the normalization
  logic [TRW-1:0] tr_dly_q [DLY];
  logic [SCW-1:0] sc_dly_q [DLY];

  always_ff @(posedge clk_i) begin
    if (en) begin
      tr_dly_q[0] <= tr_res;
      sc_dly_q[0] <= sc_res;
      for (int i = 1; i < DLY; i++) begin
        tr_dly_q[i] <= tr_dly_q[i-1];
        sc_dly_q[i] <= sc_dly_q[i-1];
      end
    end
  end

  // squares
  logic [SQW-1:0] sq_q   [QUAT_LANES];
  logic           neg4_q [QUAT_LANES];

  for (genvar l = 0; l < QUAT_LANES; l++) begin : g_sq
    localparam int SH = (QUAT_LANES - 1 - l) * RW;
    logic signed [RW-1:0]  q_s;
    logic signed [SQW-1:0] sq_d;
    assign q_s  = signed'(rot_res[SH+:RW]);
    assign sq_d = q_s * q_s;
    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_q[l]   <= unsigned'(sq_d);
        neg4_q[l] <= q_s[RW-1];
      end
    end
  end

  // root search state, index 0 is the sum-of-squares stage
  logic [SSW-1:0] s_q     [NB+1];
  logic           zero_q  [NB+1];
  logic [AW-1:0]  r_q     [NB+1][QUAT_LANES];
  logic           neg_q   [NB+1][QUAT_LANES];
  logic [AW-1:0]  acc_a_q [NB+1][QUAT_LANES];
  logic [AW-1:0]  acc_b_q [NB+1][QUAT_LANES];
  logic [NB-1:0]  n_q     [NB+1][QUAT_LANES];
  logic [SSW-1:0] s_sum;

  assign s_sum = SSW'(sq_q[0]) + SSW'(sq_q[1]) + SSW'(sq_q[2]) + SSW'(sq_q[3]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_q[0]    <= s_sum;
      zero_q[0] <= (s_sum == '0);
      for (int l = 0; l < QUAT_LANES; l++) begin
        r_q[0][l]     <= AW'(sq_q[l]) << (2 * RW - 2);
        neg_q[0][l]   <= neg4_q[l];
        acc_a_q[0][l] <= '0;
        acc_b_q[0][l] <= '0;
        n_q[0][l]     <= '0;
      end
    end
  end

  // one result bit per stage: n^2*s and n*s kept so (2n-1)^2*s needs adds only
  for (genvar j = 0; j < NB; j++) begin : g_bit
    localparam int K = NB - 1 - j;
    logic [AW-1:0] sx;
    assign sx = AW'(s_q[j]);

    for (genvar l = 0; l < QUAT_LANES; l++) begin : g_ln
      logic [AW-1:0] at, bt, lhs;
      logic          ok;
      assign at  = acc_a_q[j][l] + (acc_b_q[j][l] << (K + 1)) + (sx << (2 * K));
      assign bt  = acc_b_q[j][l] + (sx << K);
      assign lhs = (at << 2) - (bt << 2) + sx;
      assign ok  = (lhs <= r_q[j][l]);

      always_ff @(posedge clk_i) begin
        if (en) begin
          r_q[j+1][l]     <= r_q[j][l];
          neg_q[j+1][l]   <= neg_q[j][l];
          acc_a_q[j+1][l] <= ok ? at : acc_a_q[j][l];
          acc_b_q[j+1][l] <= ok ? bt : acc_b_q[j][l];
          n_q[j+1][l]     <= ok ? (n_q[j][l] | (NB'(1) << K)) : n_q[j][l];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        s_q[j+1]    <= s_q[j];
        zero_q[j+1] <= zero_q[j];
      end
    end
  end

  // saturate, restore sign
  logic [RW-1:0] rot_q [QUAT_LANES];
  logic          zl_q;

  for (genvar l = 0; l < QUAT_LANES; l++) begin : g_out
    localparam int SH = (QUAT_LANES - 1 - l) * RW;
    logic [NB-1:0] magc;
    logic [RW-1:0] mag;
    assign magc = (n_q[NB][l] > UNIT) ? UNIT : n_q[NB][l];
    assign mag  = {1'b0, magc};
    always_ff @(posedge clk_i) begin
      if (en) begin
        rot_q[l] <= zero_q[NB] ? '0 : (neg_q[NB][l] ? (RW'(0) - mag) : mag);
      end
    end
    assign out_rotation_o[SH+:RW] = rot_q[l];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      zl_q <= zero_q[NB];
    end
  end

  assign out_valid_o       = valid_q[DEPTH-1];
  assign out_translation_o = tr_dly_q[DLY-1];
  assign out_scale_o       = sc_dly_q[DLY-1];
  assign zero_length_o     = zl_q;

  a_zero_rot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_length_o |-> out_rotation_o == '0)
    else $error("zero length with nonzero rotation");

  a_nonzero_rot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !zero_length_o |-> out_rotation_o != '0)
    else $error("normalized rotation collapsed to zero");

  a_stall_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

endmodule

@@ bench/bone_transform_blend_test.sv @@
// Self-checking testbench for bone_transform_blend: directed and random pose blends.
module bone_transform_blend_test;
  import btb_pkg::*;

  localparam int TW = 20;
  localparam int RW = 16;
  localparam int SW = 16;
  localparam int WF = 16;
  localparam int TRW = XYZ_LANES * TW;
  localparam int SCW = XYZ_LANES * SW;
  localparam longint UNIT = 64'd1 << (RW - 2);
  localparam int DRAIN_CYCLES = RW + 15;

  typedef struct packed {
    logic [XYZ_LANES*TW-1:0]  a_tr;
    logic [QUAT_LANES*RW-1:0] a_rot;
    logic [XYZ_LANES*SW-1:0]  a_sc;
    logic [XYZ_LANES*TW-1:0]  b_tr;
    logic [QUAT_LANES*RW-1:0] b_rot;
    logic [XYZ_LANES*SW-1:0]  b_sc;
    logic [WF:0]              weight;
  } pose_pair_t;

  typedef struct packed {
    logic [XYZ_LANES*TW-1:0]  tr;
    logic [QUAT_LANES*RW-1:0] rot;
    logic [XYZ_LANES*SW-1:0]  sc;
    logic                     zl;
  } blended_pose_t;

  typedef struct {
    pose_pair_t    pair;
    bit            typed;
    blended_pose_t want;
  } table_row_t;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [XYZ_LANES*TW-1:0]  a_tr = '0, b_tr = '0;
  logic [QUAT_LANES*RW-1:0] a_rot = '0, b_rot = '0;
  logic [XYZ_LANES*SW-1:0]  a_sc = '0, b_sc = '0;
  logic [WF:0]              weight = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [XYZ_LANES*TW-1:0]  out_tr;
  logic [QUAT_LANES*RW-1:0] out_rot;
  logic [XYZ_LANES*SW-1:0]  out_sc;
  logic                     out_zl;

  blended_pose_t pending_poses[$];
  table_row_t    rows[$];
  int mismatches = 0;
  int poses_checked = 0;
  int zero_quats = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_request = 0;

  always #5 clk = ~clk;

  bone_transform_blend dut (
    .clk_i(clk), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .a_translation_i(a_tr), .a_rotation_i(a_rot), .a_scale_i(a_sc),
    .b_translation_i(b_tr), .b_rotation_i(b_rot), .b_scale_i(b_sc),
    .blend_weight_i(weight),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_translation_o(out_tr), .out_rotation_o(out_rot),
    .out_scale_o(out_sc), .zero_length_o(out_zl)
  );

  function automatic longint lane_of(logic [63:0] word, int lanes, int idx, int w);
    logic [63:0] raw;
    longint v;
    raw = (word >> ((lanes - 1 - idx) * w)) & ((64'd1 << w) - 1);
    v = longint'(raw);
    if (raw[w-1]) v = v - (longint'(1) << w);
    return v;
  endfunction

  // a + floor((b - a) * t / 2^WF); arithmetic shift floors toward minus infinity
  function automatic longint mix_lane(longint a, longint b, logic [WF:0] t);
    longint p;
    p = (b - a) * longint'(t);
    return a + (p >>> WF);
  endfunction

  function automatic logic [63:0] mix_vector(logic [63:0] a, logic [63:0] b,
                                             logic [WF:0] t, int lanes, int w);
    logic [63:0] r;
    longint v;
    r = '0;
    for (int i = 0; i < lanes; i++) begin
      v = mix_lane(lane_of(a, lanes, i, w), lane_of(b, lanes, i, w), t);
      r |= ((64'(v) & ((64'd1 << w) - 1)) << ((lanes - 1 - i) * w));
    end
    return r;
  endfunction

  // largest n <= UNIT with (2n-1)^2 * s <= 4 c^2 UNIT^2
  function automatic longint unit_magnitude(longint c, longint s);
    longint lo, hi, mid, d, rhs;
    lo = 0;
    hi = UNIT;
    rhs = c * c * 4 * UNIT * UNIT;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      d = 2 * mid - 1;
      if (d * d * s <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic blended_pose_t blend_pose(pose_pair_t p);
    blended_pose_t r;
    logic [WF:0] t;
    longint q[QUAT_LANES];
    longint s, n;
    t = (p.weight > (17'd1 << WF)) ? (17'd1 << WF) : p.weight;
    s = 0;
    for (int i = 0; i < QUAT_LANES; i++) begin
      q[i] = mix_lane(lane_of(p.a_rot, QUAT_LANES, i, RW),
                      lane_of(p.b_rot, QUAT_LANES, i, RW), t);
      s += q[i] * q[i];
    end
    r.zl = (s == 0);
    r.rot = '0;
    for (int i = 0; i < QUAT_LANES; i++) begin
      n = q[i];
      if (s != 0) begin
        n = unit_magnitude(q[i] < 0 ? -q[i] : q[i], s);
        if (q[i] < 0) n = -n;
      end
      r.rot = {r.rot[QUAT_LANES*RW-RW-1:0], RW'(n)};
    end
    r.tr = TRW'(mix_vector(64'(p.a_tr), 64'(p.b_tr), t, XYZ_LANES, TW));
    r.sc = SCW'(mix_vector(64'(p.a_sc), 64'(p.b_sc), t, XYZ_LANES, SW));
    return r;
  endfunction

  function automatic logic [63:0] rand_quat();
    logic [63:0] q;
    int style;
    style = $urandom_range(0, 3);
    q = '0;
    for (int i = 0; i < QUAT_LANES; i++) begin
      case (style)
        0: q = {q[47:0], 16'($urandom)};
        1: q = {q[47:0], 16'($signed($urandom_range(0, 6)) - 3)};
        2: q = {q[47:0], (i == 0) ? 16'($urandom_range(0, 1) ? 16'h4000 : 16'hC000) : 16'h0};
        default: q = {q[47:0], 16'($urandom_range(0, 32768)) - 16'd16384};
      endcase
    end
    return q;
  endfunction

  function automatic pose_pair_t rand_pair();
    pose_pair_t p;
    int pick;
    p.a_tr = TRW'({$urandom, $urandom});
    p.b_tr = TRW'({$urandom, $urandom});
    p.a_sc = SCW'({$urandom, $urandom});
    p.b_sc = SCW'({$urandom, $urandom});
    p.a_rot = rand_quat();
    pick = $urandom_range(0, 9);
    // occasionally blend toward the negated quaternion to reach zero length
    p.b_rot = (pick == 0) ? -p.a_rot : rand_quat();
    if (pick == 0) p.b_rot = {-p.a_rot[63:48], -p.a_rot[47:32], -p.a_rot[31:16], -p.a_rot[15:0]};
    pick = $urandom_range(0, 19);
    if (pick == 0) p.weight = '0;
    else if (pick == 1) p.weight = 17'd1 << WF;
    else if (pick == 2) p.weight = 17'($urandom_range(65537, 131071));
    else if (pick < 6) p.weight = 17'd1 << (WF - 1);
    else p.weight = 17'($urandom_range(0, 65536));
    return p;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    mismatches++;
  endtask

  task automatic transfer_pose(pose_pair_t p);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    {a_tr, a_rot, a_sc, b_tr, b_rot, b_sc, weight} <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_poses = {pending_poses, blend_pose(p)};
  endtask

  task automatic add_row(pose_pair_t p, bit typed, blended_pose_t want);
    table_row_t r;
    r.pair = p;
    r.typed = typed;
    r.want = want;
    rows = {rows, r};
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_poses.size() != 0) @(posedge clk);
  endtask

  // result side: check transfers, pick stall for the next cycle
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_ni && out_valid && !out_stall) begin
        if (pending_poses.size() == 0) begin
          report("unexpected transfer", out_rot, '0);
        end else begin
          blended_pose_t w;
          w = pending_poses.pop_front();
          poses_checked++;
          if (out_zl) zero_quats++;
          if (out_tr !== w.tr) report("translation", 64'(out_tr), 64'(w.tr));
          if (out_rot !== w.rot) report("rotation", out_rot, w.rot);
          if (out_sc !== w.sc) report("scale", 64'(out_sc), 64'(w.sc));
          if (out_zl !== w.zl) report("zero_length", 64'(out_zl), 64'(w.zl));
        end
      end
      if (hold_request) begin
        hold_request = 0;
        hold_left = 200;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    pose_pair_t p;
    blended_pose_t w;
    repeat (4) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // all zero: zero quaternion passes through
    p = '0;
    w = '0;
    w.zl = 1'b1;
    add_row(p, 1, w);
    // t = 0 gives a, unit quaternion unchanged
    p = rand_pair();
    p.a_rot = {16'h4000, 48'h0};
    p.weight = '0;
    w.tr = p.a_tr; w.sc = p.a_sc; w.rot = p.a_rot; w.zl = 1'b0;
    add_row(p, 1, w);
    // t = one gives b
    p = rand_pair();
    p.b_rot = {16'h0, 16'hC000, 32'h0};
    p.weight = 17'd1 << WF;
    w.tr = p.b_tr; w.sc = p.b_sc; w.rot = p.b_rot; w.zl = 1'b0;
    add_row(p, 1, w);
    // weight above one clamps to b
    p.weight = '1;
    add_row(p, 1, w);
    // opposite quaternions at half weight cancel
    p = '0;
    p.a_rot = {16'h4000, 48'h0};
    p.b_rot = {16'hC000, 48'h0};
    p.weight = 17'd1 << (WF - 1);
    w = '0;
    w.zl = 1'b1;
    add_row(p, 1, w);
    // lane extremes
    p.a_tr = {3{20'h7FFFF}}; p.b_tr = {3{20'h80000}};
    p.a_sc = {3{16'h7FFF}};  p.b_sc = {3{16'h8000}};
    p.a_rot = {4{16'h8000}}; p.b_rot = {4{16'h7FFF}};
    p.weight = '0;
    add_row(p, 0, w);
    p.weight = 17'd1;
    add_row(p, 0, w);
    p.weight = 17'h0FFFF;
    add_row(p, 0, w);
    p.a_tr = '1; p.b_tr = '0; p.a_sc = '1; p.b_sc = '0;
    p.a_rot = '1; p.b_rot = {4{16'h0001}};
    p.weight = 17'd1 << (WF - 1);
    add_row(p, 0, w);
    for (int i = 0; i < 12; i++) add_row(rand_pair(), 0, w);

    foreach (rows[i]) begin
      transfer_pose(rows[i].pair);
      if (rows[i].typed) begin
        pending_poses[pending_poses.size() - 1] = rows[i].want;
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 53 : 0;
      recv_idle_pct = (phase == 0) ? 53 : (phase == 1) ? 27 : 0;
      for (int n = 0; n < 410; n++) begin
        if (phase == 0 && n == 100) hold_request = 1;
        transfer_pose(rand_pair());
      end
      if (phase == 1) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("checked %0d blended poses over three stall mixes, %0d with zero-length rotation",
             poses_checked, zero_quats);
    if (mismatches == 0 && pending_poses.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/btb_pkg.sv
src/btb_lerp_pipe.sv
src/bone_transform_blend.sv
bench/bone_transform_blend_test.sv
